### rtl/km1d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package km1d_pkg;

  localparam int VALUE_W     = 32;
  localparam int BIT_IDX_W   = $clog2(VALUE_W);
  localparam int ERR_W       = 42;
  localparam int LABEL_OUT_W = 12;
  localparam int IDX_W       = 10;
  localparam int OP_W        = 2;
  localparam int KIND_W      = 2;
  localparam int ROUNDS_W    = 8;
  localparam int NUMK_W      = 4;
  localparam int GROUP_W     = 8;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_LABEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_CENTER = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LABEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CENTER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_INDEX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROUNDS   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [VALUE_W-1:0] sample_value;
    logic [IDX_W-1:0]   item_index;
    logic               last_sample;
  } km1d_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]      result_kind;
    logic [LABEL_OUT_W-1:0] cluster_label;
    logic [VALUE_W-1:0]     center_value;
    logic [ROUNDS_W-1:0]    rounds_done;
    logic [ERR_W-1:0]       total_error;
    logic                   hit_cap;
  } km1d_rsp_t;

  typedef struct packed {
    logic [ROUNDS_W-1:0] rounds;
    logic [ERR_W-1:0]    total_error;
    logic                hit_cap;
  } km1d_done_t;

endpackage

`default_nettype wire

### rtl/km1d_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface km1d_cmd_if;
  import km1d_pkg::*;
  logic      valid;
  logic      ready;
  km1d_cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/km1d_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface km1d_rsp_if;
  import km1d_pkg::*;
  logic      valid;
  logic      ready;
  km1d_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/kmeans_1d_cluster_engine_top.sv
// one-dimensional k-means engine
// cmd channel (valid/ready): one transaction carries opcode, sample_value,
//   item_index and last_sample. load stores a sample; a load with last_sample
//   runs clustering over all samples loaded since the previous run.
// rsp channel (valid/ready): one transaction per label read, center read or
//   finished clustering run; unknown opcodes and plain loads give none.
// config: cfg_we/cfg_index/cfg_wdata write num_clusters, group_index and
//   max_rounds; write only while the block is idle.
// throughput: one load or read is taken per cycle, back to back, while cmd
//   ready is high; a read result passes the label RAM read and pending
//   stage, then the output register, before it is on rsp.
// clustering: seeding walks the sample RAM 32 times per cluster, plus a
//   rank division per cluster; each round walks the samples on the sample
//   RAM port against every center, plus up to K serial divisions. cmd is
//   held off until the done result is queued.
// reset: registers return to defaults, no labels or centers readable; the
//   sample and label RAMs are not cleared.
// stall: a held rsp keeps one result in the output register and one more in
//   the pending stage; cmd ready drops when both are full or a run is busy.
`timescale 1ns / 1ps
`default_nettype none

module kmeans_1d_cluster_engine_top #(
  parameter int MAX_SAMPLES  = 1024,
  parameter int MAX_CLUSTERS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [km1d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [km1d_pkg::CFG_W-1:0]     cfg_wdata,
  km1d_cmd_if.sink                       cmd,
  km1d_rsp_if.source                     rsp
);
  import km1d_pkg::*;

  localparam int SW   = $clog2(MAX_SAMPLES);
  localparam int CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int LW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW   = $clog2(MAX_CLUSTERS + 1);

  // configuration registers
  logic [NUMK_W-1:0]   num_clusters;
  logic [GROUP_W-1:0]  group_index;
  logic [ROUNDS_W-1:0] max_rounds;

  // sample bookkeeping and results of the last finished run
  logic [CNTW-1:0]        sample_count;
  logic [CNTW-1:0]        n_last;
  logic [CNTW-1:0]        labeled_count;
  logic [KW-1:0]          k_lat;
  logic [LABEL_OUT_W-1:0] lab_offset;

  // core connections
  logic             core_busy;
  logic             core_done;
  km1d_done_t       core_res;
  logic [KW-1:0]    core_k;
  logic [VALUE_W-1:0] center_val;
  logic             s_re;
  logic [SW-1:0]    s_raddr;
  logic [VALUE_W-1:0] s_rdata;
  logic             l_we;
  logic [SW-1:0]    l_waddr;
  logic [LW-1:0]    l_wdata;
  logic [LW-1:0]    l_rdata;

  // pending read and output register
  logic               pend_valid;
  logic [KIND_W-1:0]  pend_kind;
  logic               pend_ok;
  logic [VALUE_W-1:0] pend_center;
  logic               out_valid;
  km1d_rsp_t          out_data;
  km1d_rsp_t          rsp_next;

  logic accept;
  logic is_load;
  logic is_label;
  logic is_center;
  logic room;
  logic core_start;
  logic [CNTW-1:0] core_n;
  logic out_free;
  logic pend_move;
  logic done_take;
  logic [LABEL_OUT_W-1:0] lab_sum;
  logic label_ok;
  logic center_ok;

  // handshakes
  assign out_free  = !out_valid || rsp.ready;
  assign pend_move = pend_valid && out_free;
  assign done_take = core_done && !pend_valid && out_free;
  assign cmd.ready = !core_busy && (!pend_valid || out_free);
  assign accept    = cmd.valid && cmd.ready;

  assign is_load   = accept && (cmd.data.opcode == OP_LOAD);
  assign is_label  = accept && (cmd.data.opcode == OP_LABEL);
  assign is_center = accept && (cmd.data.opcode == OP_CENTER);

  // loads past the store depth are dropped, a last mark still starts a run
  assign room       = (sample_count < CNTW'(MAX_SAMPLES));
  assign core_n     = room ? sample_count + CNTW'(1) : sample_count;
  assign core_start = is_load && cmd.data.last_sample;

  assign label_ok  = (32'(cmd.data.item_index) < 32'(labeled_count));
  assign center_ok = (32'(cmd.data.item_index) < 32'(k_lat));
  assign lab_sum   = LABEL_OUT_W'(l_rdata) + lab_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= NUMK_W'(2);
      group_index  <= '0;
      max_rounds   <= ROUNDS_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_CLUSTERS: num_clusters <= cfg_wdata[NUMK_W-1:0];
        REG_GROUP_INDEX:  group_index  <= cfg_wdata[GROUP_W-1:0];
        REG_MAX_ROUNDS:   max_rounds   <= cfg_wdata[ROUNDS_W-1:0];
        default: ;
      endcase
    end
  end

  // sample count restarts at zero once a run begins
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= '0;
      labeled_count <= '0;
      k_lat         <= '0;
      lab_offset    <= '0;
    end else begin
      if (core_start) begin
        sample_count <= '0;
        n_last       <= core_n;
      end else if (is_load && room) begin
        sample_count <= sample_count + CNTW'(1);
      end
      // labels and centers of the new run become visible once done is queued
      if (done_take) begin
        labeled_count <= n_last;
        k_lat         <= core_k;
        lab_offset    <= LABEL_OUT_W'(32'(group_index) * 32'(core_k) + 32'd1);
      end
    end
  end

  // pending stage covers the label RAM read latency
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      if (pend_move) pend_valid <= 1'b0;
      if (is_label || is_center) pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (is_label) begin
      pend_kind <= KIND_LABEL;
      pend_ok   <= label_ok;
    end else if (is_center) begin
      pend_kind   <= KIND_CENTER;
      pend_center <= center_ok ? center_val : '0;
    end
  end

  always_comb begin
    rsp_next = '0;
    if (pend_valid) begin
      rsp_next.result_kind = pend_kind;
      if (pend_kind == KIND_LABEL) rsp_next.cluster_label = pend_ok ? lab_sum : '0;
      else rsp_next.center_value = pend_center;
    end else begin
      rsp_next.result_kind = KIND_DONE;
      rsp_next.rounds_done = core_res.rounds;
      rsp_next.total_error = core_res.total_error;
      rsp_next.hit_cap     = core_res.hit_cap;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) out_valid <= 1'b0;
      if (pend_move || done_take) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move || done_take) out_data <= rsp_next;
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  km1d_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_SAMPLES)) u_sample_ram (
    .clk   (clk),
    .we    (is_load && room),
    .waddr (SW'(sample_count)),
    .wdata (cmd.data.sample_value),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  km1d_ram #(.WIDTH(LW), .DEPTH(MAX_SAMPLES)) u_label_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (is_label),
    .raddr (SW'(cmd.data.item_index)),
    .rdata (l_rdata)
  );

  km1d_core #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_CLUSTERS(MAX_CLUSTERS)) u_core (
    .clk          (clk),
    .rst          (rst),
    .start        (core_start),
    .n            (core_n),
    .num_clusters (num_clusters),
    .max_rounds   (max_rounds),
    .s_re         (s_re),
    .s_raddr      (s_raddr),
    .s_rdata      (s_rdata),
    .l_we         (l_we),
    .l_waddr      (l_waddr),
    .l_wdata      (l_wdata),
    .center_idx   (LW'(cmd.data.item_index)),
    .center_val   (center_val),
    .busy         (core_busy),
    .done_valid   (core_done),
    .done_ack     (done_take),
    .res          (core_res),
    .k_out        (core_k)
  );

endmodule

`default_nettype wire

### rtl/km1d_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module km1d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

`default_nettype wire

### rtl/km1d_div.sv
`timescale 1ns / 1ps
`default_nettype none

module km1d_div #(
  parameter int NW = 43,
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic          run;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [DW:0]   rsh;
  logic [DW:0]   trial;

  // one quotient bit per cycle, restoring
  assign rsh   = {rem, quo[NW-1]};
  assign trial = rsh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= CW'(NW);
        rem   <= '0;
        quo   <= num;
        den_r <= den;
      end else if (run) begin
        if (!trial[DW]) begin
          rem <= trial[DW-1:0];
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= rsh[DW-1:0];
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

`default_nettype wire

### rtl/km1d_core.sv
`timescale 1ns / 1ps
`default_nettype none

module km1d_core #(
  parameter int MAX_SAMPLES  = 1024,
  parameter int MAX_CLUSTERS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0]        n,
  input  logic [km1d_pkg::NUMK_W-1:0]             num_clusters,
  input  logic [km1d_pkg::ROUNDS_W-1:0]           max_rounds,
  output logic                                    s_re,
  output logic [$clog2(MAX_SAMPLES)-1:0]          s_raddr,
  input  logic [km1d_pkg::VALUE_W-1:0]            s_rdata,
  output logic                                    l_we,
  output logic [$clog2(MAX_SAMPLES)-1:0]          l_waddr,
  output logic [((MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1)-1:0] l_wdata,
  input  logic [((MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1)-1:0] center_idx,
  output logic [km1d_pkg::VALUE_W-1:0]            center_val,
  output logic                                    busy,
  output logic                                    done_valid,
  input  logic                                    done_ack,
  output km1d_pkg::km1d_done_t                    res,
  output logic [$clog2(MAX_CLUSTERS+1)-1:0]       k_out
);
  import km1d_pkg::*;

  localparam int SW   = $clog2(MAX_SAMPLES);
  localparam int CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int LW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW   = $clog2(MAX_CLUSTERS + 1);
  localparam int SUMW = VALUE_W + CNTW;
  localparam int DVW  = (CNTW > KW + 1) ? CNTW : KW + 1;
  localparam int VW   = VALUE_W;
  localparam int BW   = BIT_IDX_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RANK  = 4'd1;
  localparam logic [3:0] S_RANKW = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_BIT   = 4'd4;
  localparam logic [3:0] S_AINIT = 4'd5;
  localparam logic [3:0] S_ARD   = 4'd6;
  localparam logic [3:0] S_ACMP  = 4'd7;
  localparam logic [3:0] S_AUPD  = 4'd8;
  localparam logic [3:0] S_AEND  = 4'd9;
  localparam logic [3:0] S_UPD   = 4'd10;
  localparam logic [3:0] S_UPDW  = 4'd11;
  localparam logic [3:0] S_CHK1  = 4'd12;
  localparam logic [3:0] S_CHK2  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]          state;
  logic [CNTW-1:0]     n_run;
  logic [KW-1:0]       k_run;
  logic [ROUNDS_W-1:0] cap_run;
  logic [KW-1:0]       c;
  logic [LW-1:0]       j;
  logic [LW-1:0]       best;
  logic [CNTW-1:0]     s;
  logic                rd_vld;
  logic [CNTW-1:0]     rank;
  logic [VW-1:0]       pref;
  logic [BW-1:0]       bitn;
  logic [CNTW-1:0]     cnt;
  logic [VW-1:0]       bd;
  logic [SUMW-1:0]     err;
  logic [SUMW-1:0]     new_err;
  logic [SUMW-1:0]     old_err;
  logic [SUMW+6:0]     d100;
  logic [ROUNDS_W-1:0] rounds;
  logic                hit;
  logic                first;

  logic [VW-1:0]       centers [MAX_CLUSTERS];
  logic [SUMW-1:0]     sums    [MAX_CLUSTERS];
  logic [CNTW-1:0]     counts  [MAX_CLUSTERS];

  logic                div_start;
  logic [SUMW-1:0]     div_num;
  logic [DVW-1:0]      div_den;
  logic                div_done;
  logic [SUMW-1:0]     div_quo;

  logic [LW-1:0]       csel;
  logic [VW-1:0]       cval;
  logic [VW-1:0]       x;
  logic [VW-1:0]       gap;
  logic [LW-1:0]       aidx;
  logic [SUMW-1:0]     sum_sel;
  logic [CNTW-1:0]     cnt_sel;
  logic [VW-1:0]       hmask;
  logic [VW-1:0]       bitmask;
  logic                match;
  logic [31:0]         kc;
  logic [KW-1:0]       k_eff;
  logic [ROUNDS_W-1:0] cap_eff;
  logic [CNTW-1:0]     rank_q;
  logic [SUMW-1:0]     rank_num;
  logic [SUMW-1:0]     ediff;
  logic                last_c;

  assign csel    = (state == S_ACMP) ? j : center_idx;
  assign cval    = centers[csel];
  assign x       = s_rdata;
  assign gap     = (x >= cval) ? x - cval : cval - x;
  assign aidx    = (state == S_AUPD) ? best : LW'(c);
  assign sum_sel = sums[aidx];
  assign cnt_sel = counts[aidx];
  assign last_c  = (c == k_run - KW'(1));

  // a sample matches when the bits above the one being decided equal the prefix found so far and that bit is zero
  assign hmask   = ~({VW{1'b1}} >> (BW'(VW - 1) - bitn));
  assign bitmask = VW'(1) << bitn;
  assign match   = (((x ^ pref) & hmask) == '0) && !x[bitn];

  assign kc      = (num_clusters == '0) ? 32'd1 :
                   ((32'(num_clusters) > MAX_CLUSTERS) ? MAX_CLUSTERS : 32'(num_clusters));
  assign k_eff   = KW'(kc);
  assign cap_eff = (max_rounds < ROUNDS_W'(2)) ? ROUNDS_W'(2) : max_rounds;

  assign rank_num = SUMW'((32'(c) * 32'd2 + 32'd1) * 32'(n_run));
  assign rank_q   = (div_quo >= SUMW'(n_run)) ? n_run - CNTW'(1) : CNTW'(div_quo);
  assign ediff    = (new_err >= old_err) ? new_err - old_err : old_err - new_err;

  assign div_start = (state == S_RANK) || (state == S_UPD && cnt_sel != '0);
  assign div_num   = (state == S_RANK) ? rank_num : sum_sel;
  assign div_den   = (state == S_RANK) ? DVW'(32'(k_run) * 32'd2) : DVW'(cnt_sel);

  km1d_div #(.NW(SUMW), .DW(DVW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            n_run   <= n;
            k_run   <= k_eff;
            cap_run <= cap_eff;
            c       <= '0;
            first   <= 1'b1;
            state   <= S_RANK;
          end
        end
        S_RANK: state <= S_RANKW;
        S_RANKW: begin
          if (div_done) begin
            rank   <= rank_q;
            pref   <= '0;
            bitn   <= BW'(VW - 1);
            s      <= '0;
            cnt    <= '0;
            rd_vld <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld <= (s < n_run);
          if (s < n_run) s <= s + CNTW'(1);
          if (rd_vld && match) cnt <= cnt + CNTW'(1);
          if (s == n_run && !rd_vld) state <= S_BIT;
        end
        S_BIT: begin
          if (rank >= cnt) begin
            pref <= pref | bitmask;
            rank <= rank - cnt;
          end
          if (bitn == '0) begin
            centers[LW'(c)] <= (rank >= cnt) ? (pref | bitmask) : pref;
            if (last_c) begin
              state <= S_AINIT;
            end else begin
              c     <= c + KW'(1);
              state <= S_RANK;
            end
          end else begin
            bitn  <= bitn - BW'(1);
            s     <= '0;
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_AINIT: begin
          for (int i = 0; i < MAX_CLUSTERS; i++) begin
            sums[i]   <= '0;
            counts[i] <= '0;
          end
          err   <= '0;
          s     <= '0;
          state <= S_ARD;
        end
        S_ARD: begin
          j     <= '0;
          state <= S_ACMP;
        end
        S_ACMP: begin
          if (j == '0 || gap < bd) begin
            bd   <= gap;
            best <= j;
          end
          if (KW'(j) == k_run - KW'(1)) state <= S_AUPD;
          else j <= j + LW'(1);
        end
        S_AUPD: begin
          sums[best]   <= sum_sel + SUMW'(x);
          counts[best] <= cnt_sel + CNTW'(1);
          err          <= err + SUMW'(bd);
          s            <= s + CNTW'(1);
          if (s == n_run - CNTW'(1)) state <= S_AEND;
          else state <= S_ARD;
        end
        S_AEND: begin
          if (first) begin
            new_err <= err;
            old_err <= '0;
            rounds  <= '0;
            first   <= 1'b0;
            c       <= '0;
            state   <= S_UPD;
          end else begin
            old_err <= new_err;
            new_err <= err;
            rounds  <= rounds + ROUNDS_W'(1);
            state   <= S_CHK1;
          end
        end
        S_UPD: begin
          if (cnt_sel != '0) state <= S_UPDW;
          else if (last_c) state <= S_AINIT;
          else c <= c + KW'(1);
        end
        S_UPDW: begin
          if (div_done) begin
            centers[LW'(c)] <= VW'(div_quo);
            if (last_c) begin
              state <= S_AINIT;
            end else begin
              c     <= c + KW'(1);
              state <= S_UPD;
            end
          end
        end
        S_CHK1: begin
          // times 100 as 64 + 32 + 4
          d100  <= ({7'd0, ediff} << 6) + ({7'd0, ediff} << 5) + ({7'd0, ediff} << 2);
          state <= S_CHK2;
        end
        S_CHK2: begin
          if (rounds >= ROUNDS_W'(2) && d100 <= {7'd0, old_err}) begin
            hit   <= 1'b0;
            state <= S_DONE;
          end else if (rounds >= cap_run) begin
            hit   <= 1'b1;
            state <= S_DONE;
          end else begin
            c     <= '0;
            state <= S_UPD;
          end
        end
        S_DONE: begin
          if (done_ack) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_re    = (state == S_SCAN && s < n_run) || (state == S_ARD);
  assign s_raddr = SW'(s);
  assign l_we    = (state == S_AUPD);
  assign l_waddr = SW'(s);
  assign l_wdata = best;

  assign center_val      = cval;
  assign busy            = (state != S_IDLE);
  assign done_valid      = (state == S_DONE);
  assign res.rounds      = rounds;
  assign res.total_error = ERR_W'(new_err);
  assign res.hit_cap     = hit;
  assign k_out           = k_run;

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_RANKW || state == S_UPDW))
    else $error("divider finished outside a wait state");

  a_label_in_range: assert property (@(posedge clk) disable iff (rst)
    l_we |-> (s < n_run))
    else $error("label write beyond sample count");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (done_valid && !done_ack) |=> done_valid)
    else $error("done dropped without acknowledge");

  a_round_bounds: assert property (@(posedge clk) disable iff (rst)
    done_valid |-> (rounds >= ROUNDS_W'(2) && rounds <= cap_run))
    else $error("round count out of bounds at done");

endmodule

`default_nettype wire

### tb/sv/km1d_checker.sv
`timescale 1ns / 1ps

module km1d_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [km1d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [km1d_pkg::CFG_W-1:0]     cfg_wdata,
  km1d_cmd_if                            cmd,
  km1d_rsp_if                            rsp,
  output int                             errors,
  output int                             pending
);
  import km1d_pkg::*;

  localparam int DEPTH = 1024;
  localparam int KMAX  = 8;

  // shadow registers
  logic [NUMK_W-1:0]   k_reg;
  logic [GROUP_W-1:0]  g_reg;
  logic [ROUNDS_W-1:0] cap_reg;

  // shadow datapath state
  logic [VALUE_W-1:0] samples [DEPTH];
  logic [VALUE_W-1:0] sorted_vals [DEPTH];
  logic [2:0]         labels [DEPTH];
  logic [VALUE_W-1:0] centers [KMAX];
  logic [63:0]        sums [KMAX];
  int                 members [KMAX];
  int                 n_loaded;
  int                 n_labeled;
  int                 k_used;
  int                 g_used;

  km1d_rsp_t expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [63:0] abs_gap(logic [63:0] a, logic [63:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // nearest-center assignment, ties to the lowest index; returns total error
  function automatic logic [63:0] assign_samples(int n, int k);
    logic [63:0] err;
    logic [63:0] bd;
    logic [63:0] d;
    int best;
    err = 0;
    for (int c = 0; c < KMAX; c++) begin
      sums[c] = 0;
      members[c] = 0;
    end
    for (int s = 0; s < n; s++) begin
      best = 0;
      bd = abs_gap(samples[s], centers[0]);
      for (int j = 1; j < k; j++) begin
        d = abs_gap(samples[s], centers[j]);
        if (d < bd) begin
          bd = d;
          best = j;
        end
      end
      labels[s] = best[2:0];
      sums[best] += samples[s];
      members[best]++;
      err += bd;
    end
    return err;
  endfunction

  function automatic km1d_rsp_t cluster_pass(int n);
    km1d_rsp_t r;
    int k;
    int cap;
    int rounds;
    int j;
    logic [63:0] v;
    logic [63:0] rank;
    logic [63:0] err_old;
    logic [63:0] err_new;
    logic capped;
    k = (k_reg == 0) ? 1 : (k_reg > KMAX) ? KMAX : int'(k_reg);
    cap = (cap_reg < 2) ? 2 : int'(cap_reg);
    // order statistics for seeding
    for (int i = 0; i < n; i++) begin
      v = samples[i];
      j = i;
      while (j > 0 && sorted_vals[j-1] > v) begin
        sorted_vals[j] = sorted_vals[j-1];
        j--;
      end
      sorted_vals[j] = v[VALUE_W-1:0];
    end
    for (int c = 0; c < KMAX; c++) centers[c] = 0;
    for (int c = 0; c < k; c++) begin
      rank = (64'(2 * c + 1) * 64'(n)) / 64'(2 * k);
      if (rank >= 64'(n)) rank = 64'(n - 1);
      centers[c] = sorted_vals[rank];
    end
    err_new = assign_samples(n, k);
    rounds = 0;
    capped = 1'b0;
    forever begin
      for (int c = 0; c < k; c++)
        if (members[c] != 0) centers[c] = VALUE_W'(sums[c] / 64'(members[c]));
      err_old = err_new;
      err_new = assign_samples(n, k);
      rounds++;
      if (rounds >= 2 && 100 * abs_gap(err_new, err_old) <= err_old) break;
      if (rounds >= cap) begin
        capped = 1'b1;
        break;
      end
    end
    n_labeled = n;
    k_used = k;
    g_used = int'(g_reg);
    r = '0;
    r.result_kind = KIND_DONE;
    r.rounds_done = rounds[ROUNDS_W-1:0];
    r.total_error = err_new[ERR_W-1:0];
    r.hit_cap = capped;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_result(km1d_rsp_t got);
    km1d_rsp_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected result, kind", 64'(got.result_kind), 64'(0));
      return;
    end
    want = expected_q.pop_front();
    if (got.result_kind !== want.result_kind)
      report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
    if (got.cluster_label !== want.cluster_label)
      report_mismatch("cluster_label", 64'(got.cluster_label), 64'(want.cluster_label));
    if (got.center_value !== want.center_value)
      report_mismatch("center_value", 64'(got.center_value), 64'(want.center_value));
    if (got.rounds_done !== want.rounds_done)
      report_mismatch("rounds_done", 64'(got.rounds_done), 64'(want.rounds_done));
    if (got.total_error !== want.total_error)
      report_mismatch("total_error", 64'(got.total_error), 64'(want.total_error));
    if (got.hit_cap !== want.hit_cap)
      report_mismatch("hit_cap", 64'(got.hit_cap), 64'(want.hit_cap));
  endtask

  task automatic take_command(km1d_cmd_t c);
    km1d_rsp_t r;
    logic [63:0] lab;
    r = '0;
    case (c.opcode)
      OP_LOAD: begin
        if (n_loaded < DEPTH) begin
          samples[n_loaded] = c.sample_value;
          n_loaded++;
        end
        if (c.last_sample) begin
          r = cluster_pass(n_loaded);
          expected_q = {expected_q, r};
          n_loaded = 0;
        end
      end
      OP_LABEL: begin
        r.result_kind = KIND_LABEL;
        if (int'(c.item_index) < n_labeled) begin
          lab = 64'(labels[c.item_index]) + 64'(g_used) * 64'(k_used) + 1;
          r.cluster_label = lab[LABEL_OUT_W-1:0];
        end
        expected_q = {expected_q, r};
      end
      OP_CENTER: begin
        r.result_kind = KIND_CENTER;
        if (int'(c.item_index) < k_used) r.center_value = centers[c.item_index];
        expected_q = {expected_q, r};
      end
      default: ;
    endcase
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      k_reg <= 4'd2;
      g_reg <= '0;
      cap_reg <= 8'd64;
      n_loaded = 0;
      n_labeled = 0;
      k_used = 0;
      g_used = 0;
      for (int c = 0; c < KMAX; c++) centers[c] = 0;
    end else begin
      // results first: a result never belongs to a command accepted on the same edge
      if (rsp.valid && rsp.ready) check_result(rsp.data);
      if (cmd.valid && cmd.ready) take_command(cmd.data);
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_CLUSTERS: k_reg <= cfg_wdata[NUMK_W-1:0];
          REG_GROUP_INDEX:  g_reg <= cfg_wdata[GROUP_W-1:0];
          REG_MAX_ROUNDS:   cap_reg <= cfg_wdata[ROUNDS_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/sv/tb_kmeans_1d_cluster_engine_top.sv
`timescale 1ns / 1ps

module tb_kmeans_1d_cluster_engine_top;
  import km1d_pkg::*;

  // opcode that the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // random-phase stimulus target
  localparam int RANDOM_ITEMS = 480;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int fail_count;
  int in_flight;

  km1d_cmd_if cmd ();
  km1d_rsp_if rsp ();

  kmeans_1d_cluster_engine_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .rsp       (rsp)
  );

  km1d_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .rsp       (rsp),
    .errors    (fail_count),
    .pending   (in_flight)
  );

  // 50 MHz clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // hard stop; clustering runs on big sample sets are slow
  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

  // sender burst state
  int burst_left;
  int random_sent;
  // long receiver hold-off request, cleared by the receiver once served
  logic hold_req;

  // ---------------------------------------------------------------------------
  // receiver: random stall patterns; one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    rsp.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 64; i++) begin
        @(negedge clk);
        if (hold_req) begin
          // hold off long enough that the block's output stages fill and cmd stalls
          rsp.ready = 1'b0;
          repeat (300) @(negedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0: rsp.ready = 1'b1;
          1: rsp.ready = ($urandom_range(0, 1) == 1);
          2: rsp.ready = ($urandom_range(0, 9) != 0);
          default: rsp.ready = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one cmd transaction; valid stays high into the next transaction inside a burst
  task automatic send(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val,
                      logic [IDX_W-1:0] idx, logic last, bit no_gap = 0);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (!no_gap) begin
        @(negedge clk);
        cmd.valid = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    cmd.valid = 1'b1;
    cmd.data.opcode = op;
    cmd.data.sample_value = val;
    cmd.data.item_index = idx;
    cmd.data.last_sample = last;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic load(logic [VALUE_W-1:0] val, logic last = 1'b0);
    send(OP_LOAD, val, '0, last);
  endtask

  // wait for every expected result, then let the read pipeline settle
  task automatic drain();
    @(negedge clk);
    cmd.valid = 1'b0;
    while (in_flight != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // clustered values around a base, or anything at all
  function automatic logic [VALUE_W-1:0] pick_sample(logic [VALUE_W-1:0] base);
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return base;
      default: return base + $urandom_range(0, 32'h0003_ffff);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_cap();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd255;
      4: return 8'd64;
      default: return CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    int k;
    logic [VALUE_W-1:0] bases [8];
    bit hold_done;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cmd.valid = 1'b0;
    cmd.data = '0;
    hold_req = 1'b0;
    burst_left = 0;
    random_sent = 0;
    hold_done = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // nothing clustered yet: reads return zero, unknown opcode is dropped
    send(OP_LABEL, '0, '0, 1'b0);
    send(OP_CENTER, '0, '0, 1'b0);
    send(OP_UNUSED, 32'hffff_ffff, '1, 1'b1);
    send(OP_CENTER, '0, '1, 1'b0);

    // value extremes and tied distances with reset registers
    load(32'h0000_0000);
    load(32'hffff_ffff);
    load(32'd5);
    load(32'd5, 1'b1);
    for (int i = 0; i < 5; i++) send(OP_LABEL, '0, IDX_W'(i), 1'b0);
    send(OP_LABEL, '0, '1, 1'b0);
    for (int i = 0; i < 3; i++) send(OP_CENTER, '0, IDX_W'(i), 1'b0);
    drain();

    // K of zero acts as one, cap below two acts as two, largest group
    write_reg(REG_NUM_CLUSTERS, 8'd0);
    write_reg(REG_GROUP_INDEX, 8'd255);
    write_reg(REG_MAX_ROUNDS, 8'd0);
    load(32'h0001_0000);
    load(32'h0002_8000, 1'b1);
    send(OP_LABEL, '0, 10'd1, 1'b0);
    send(OP_CENTER, '0, 10'd0, 1'b0);
    send(OP_CENTER, '0, 10'd1, 1'b0);
    drain();

    // K above the maximum clamps to eight, fewer samples than clusters
    write_reg(REG_NUM_CLUSTERS, 8'd15);
    write_reg(REG_MAX_ROUNDS, 8'd1);
    load(32'd100);
    load(32'd7);
    load(32'd100_000, 1'b1);
    send(OP_CENTER, '0, 10'd7, 1'b0);
    send(OP_LABEL, '0, 10'd2, 1'b0);
    drain();

    // K of eight with group 255 reaches the widest label value
    write_reg(REG_NUM_CLUSTERS, 8'd8);
    write_reg(REG_MAX_ROUNDS, 8'd255);
    for (int i = 0; i < 16; i++) load(32'(i) << 27, 1'(i == 15));
    for (int i = 14; i < 16; i++) send(OP_LABEL, '0, IDX_W'(i), 1'b0);
    drain();

    write_reg(REG_NUM_CLUSTERS, 8'd2);
    write_reg(REG_GROUP_INDEX, 8'd0);
    write_reg(REG_MAX_ROUNDS, 8'd8);

    // random phases: registers, a sample set with noise, then reads
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        k = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        write_reg(REG_NUM_CLUSTERS, CFG_W'(k));
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_GROUP_INDEX, CFG_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 2) == 0) write_reg(REG_MAX_ROUNDS, pick_cap());

      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(2, 24);
      for (int b = 0; b < 8; b++) bases[b] = $urandom();
      for (int i = 0; i < n; i++) begin
        // stray reads and ignored opcodes in the middle of a load
        if ($urandom_range(0, 9) == 0) begin
          send(($urandom_range(0, 2) == 0) ? OP_UNUSED : OP_LABEL,
               $urandom(), IDX_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
          random_sent++;
        end
        load(pick_sample(bases[$urandom_range(0, 7)]), 1'(i == n - 1));
        random_sent++;
      end

      // once, let the receiver hold off while reads keep coming
      if (!hold_done && random_sent > RANDOM_ITEMS / 2) begin
        hold_done = 1;
        @(negedge clk);
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
          send(OP_LABEL, '0, IDX_W'($urandom_range(0, n - 1)), 1'b0, 1);
          random_sent++;
        end
      end

      repeat ($urandom_range(3, 20)) begin
        if ($urandom_range(0, 1) == 0)
          send(OP_LABEL, $urandom(),
               IDX_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, n - 1)),
               1'($urandom_range(0, 1)));
        else
          send(OP_CENTER, $urandom(),
               IDX_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 8)),
               1'($urandom_range(0, 1)));
        random_sent++;
      end
      drain();
    end

    drain();
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
